### hw/rtl/sdcm_pkg.sv
// sdcm_pkg: shared widths, constants and the twiddle type for the
// down-conversion / conjugate-multiply block; depends on nothing else.
package sdcm_pkg;

	// defaults for the top level parameters
	localparam int BINS_DEF        = 128;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int VALUE_BITS_DEF  = 24;

	// fixed index field widths
	localparam int ROW_BITS     = 10;
	localparam int BIN_IDX_BITS = 7;

	// twiddle format: Q1.17, range -1.0 .. +1.0 inclusive needs 19 bits
	localparam int TW_FRAC = 17;
	localparam int TW_BITS = TW_FRAC + 2;

	// fixed-point constants for the twiddle series, Q30
	localparam longint unsigned PI_Q30  = 64'd3373259426;
	localparam longint unsigned ONE_Q30 = 64'd1073741824;

	// pipeline depth from input register to output register
	localparam int STAGES = 7;

	typedef struct packed {
		logic signed [TW_BITS-1:0] cos_v;
		logic signed [TW_BITS-1:0] sin_v;
	} twiddle_t;

endpackage

### hw/rtl/ssca_downconvert_conj_multiply.sv
// ssca_downconvert_conj_multiply: top level, bin * twiddle * conj(centre)
// with rounding and saturation; uses sdcm_pkg and sdcm_twiddle_rom.
//
// usage
//   s_axis carries one shifted first-FFT bin, the row's centre sample and the
//   row and bin numbers per item; m_axis returns the saturated product, with
//   tuser high when either part was clipped. one result per input item.
//   the twiddle index p = ((k + BINS/2) * m) mod BINS is formed from the low
//   bits of the indices, so BINS must be a power of two; this is not checked.
//   seven register stages, in order: index product, twiddle table read,
//   twiddle by centre products, their sums, bin by that products, rounding
//   sums, shift and clamp. throughput is one item per cycle while
//   m_axis_tready is high; each stage holds one item and moves on when the
//   stage after it is empty or moving, so bubbles close up.
//   when m_axis_tready is low the output holds its item and the stages fill
//   behind it; s_axis_tready falls only once all seven stages hold items.
//   reset clears every valid bit at once; no item is in flight afterwards
//   and the block takes an item in the first cycle after reset is released.
module ssca_downconvert_conj_multiply
	import sdcm_pkg::*;
#(
	parameter int BINS        = BINS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// bin_re, bin_im, center_re, center_im, row_index, bin_index, zero fill
	input  logic [((2*VALUE_BITS+2*SAMPLE_BITS+ROW_BITS+BIN_IDX_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// prod_re, prod_im, zero fill
	output logic [((2*VALUE_BITS+7)/8)*8-1:0] m_axis_tdata,
	// saturated
	output logic m_axis_tuser
);

	localparam int V        = VALUE_BITS;
	localparam int S        = SAMPLE_BITS;
	localparam int BIN_BITS = $clog2(BINS);
	localparam int OUT_W    = ((2*V+7)/8)*8;
	localparam int OFF_BIM  = V;
	localparam int OFF_CRE  = 2*V;
	localparam int OFF_CIM  = 2*V + S;
	localparam int OFF_ROW  = 2*V + 2*S;
	localparam int OFF_BIN  = 2*V + 2*S + ROW_BITS;
	localparam int TC_W     = TW_BITS + S;       // twiddle by centre product
	localparam int A_W      = TC_W + 1;          // w * conj(c)
	localparam int M_W      = V + A_W;           // bin by A product
	localparam int SUM_W    = M_W + 2;           // product sum plus rounding
	localparam int SH       = S + 16;
	localparam int R_W      = SUM_W - SH;

	localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (SH - 1);
	localparam logic [BIN_BITS-1:0]     HALF_BINS = BIN_BITS'(BINS / 2);

	// ------------------------------------------------------------------
	// stage handshake: a stage loads when it is empty or its successor loads
	logic [STAGES-1:0] valid_q;
	logic [STAGES:0]   adv;
	logic [STAGES-1:0] valid_in;

	always_comb begin
		adv[STAGES] = m_axis_tready;
		for (int i = STAGES - 1; i >= 0; i--)
			adv[i] = !valid_q[i] || adv[i+1];
	end

	assign valid_in = {valid_q[STAGES-2:0], s_axis_tvalid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int i = 0; i < STAGES; i++)
				if (adv[i])
					valid_q[i] <= valid_in[i];
		end
	end

	assign s_axis_tready = adv[0];
	assign m_axis_tvalid = valid_q[STAGES-1];

	// ------------------------------------------------------------------
	// stage 1: unpack, twiddle index
	logic [BIN_BITS-1:0]   m_mod, k_mod, ks;
	logic [2*BIN_BITS-1:0] p_full;

	assign m_mod  = BIN_BITS'({{BIN_BITS{1'b0}}, s_axis_tdata[OFF_ROW +: ROW_BITS]});
	assign k_mod  = BIN_BITS'({{BIN_BITS{1'b0}}, s_axis_tdata[OFF_BIN +: BIN_IDX_BITS]});
	assign ks     = k_mod + HALF_BINS;
	assign p_full = (2*BIN_BITS)'(ks) * (2*BIN_BITS)'(m_mod);

	logic signed [V-1:0]   bre_s1, bim_s1, bre_s2, bim_s2, bre_s3, bim_s3, bre_s4, bim_s4;
	logic signed [S-1:0]   cre_s1, cim_s1, cre_s2, cim_s2;
	logic [BIN_BITS-1:0]   p_s1;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			bre_s1 <= s_axis_tdata[0 +: V];
			bim_s1 <= s_axis_tdata[OFF_BIM +: V];
			cre_s1 <= s_axis_tdata[OFF_CRE +: S];
			cim_s1 <= s_axis_tdata[OFF_CIM +: S];
			p_s1   <= p_full[BIN_BITS-1:0];
		end
	end

	// stage 2: twiddle table read
	twiddle_t tw_s2;

	sdcm_twiddle_rom #(
		.BINS     (BINS),
		.BIN_BITS (BIN_BITS)
	) u_rom (
		.clk (clk),
		.en  (adv[1]),
		.p   (p_s1),
		.tw  (tw_s2)
	);

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			bre_s2 <= bre_s1;
			bim_s2 <= bim_s1;
			cre_s2 <= cre_s1;
			cim_s2 <= cim_s1;
		end
	end

	// stage 3: twiddle by centre products, w = cos - j*sin
	logic signed [TW_BITS-1:0] wr, wi;
	logic signed [TC_W-1:0]    rr_s3, ii_s3, ir_s3, ri_s3;

	assign wr = tw_s2.cos_v;
	assign wi = -tw_s2.sin_v;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			rr_s3  <= TC_W'(wr) * TC_W'(cre_s2);
			ii_s3  <= TC_W'(wi) * TC_W'(cim_s2);
			ir_s3  <= TC_W'(wi) * TC_W'(cre_s2);
			ri_s3  <= TC_W'(wr) * TC_W'(cim_s2);
			bre_s3 <= bre_s2;
			bim_s3 <= bim_s2;
		end
	end

	// stage 4: A = w * conj(c)
	logic signed [A_W-1:0] ar_s4, ai_s4;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			ar_s4  <= A_W'(rr_s3) + A_W'(ii_s3);
			ai_s4  <= A_W'(ir_s3) - A_W'(ri_s3);
			bre_s4 <= bre_s3;
			bim_s4 <= bim_s3;
		end
	end

	// stage 5: bin by A products
	logic signed [M_W-1:0] brar_s5, biai_s5, brai_s5, biar_s5;

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			brar_s5 <= M_W'(bre_s4) * M_W'(ar_s4);
			biai_s5 <= M_W'(bim_s4) * M_W'(ai_s4);
			brai_s5 <= M_W'(bre_s4) * M_W'(ai_s4);
			biar_s5 <= M_W'(bim_s4) * M_W'(ar_s4);
		end
	end

	// stage 6: complex sums with the rounding half
	logic signed [SUM_W-1:0] re_s6, im_s6;

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			re_s6 <= SUM_W'(brar_s5) - SUM_W'(biai_s5) + HALF;
			im_s6 <= SUM_W'(brai_s5) + SUM_W'(biar_s5) + HALF;
		end
	end

	// stage 7: shift back to the bin scale and clamp
	logic signed [R_W-1:0] re_sh, im_sh;
	logic                  re_ovf, im_ovf;
	logic signed [V-1:0]   re_cl, im_cl;

	assign re_sh = R_W'(re_s6 >>> SH);
	assign im_sh = R_W'(im_s6 >>> SH);

	// out of range when the bits above the sign are not all equal to it
	assign re_ovf = !((&re_sh[R_W-1:V-1]) || !(|re_sh[R_W-1:V-1]));
	assign im_ovf = !((&im_sh[R_W-1:V-1]) || !(|im_sh[R_W-1:V-1]));

	always_comb begin
		re_cl = re_sh[V-1:0];
		if (re_ovf)
			re_cl = re_sh[R_W-1] ? {1'b1, {(V-1){1'b0}}} : {1'b0, {(V-1){1'b1}}};
		im_cl = im_sh[V-1:0];
		if (im_ovf)
			im_cl = im_sh[R_W-1] ? {1'b1, {(V-1){1'b0}}} : {1'b0, {(V-1){1'b1}}};
	end

	logic signed [V-1:0] pre_s7, pim_s7;
	logic                sat_s7;

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			pre_s7 <= re_cl;
			pim_s7 <= im_cl;
			sat_s7 <= re_ovf || im_ovf;
		end
	end

	assign m_axis_tdata = OUT_W'({pim_s7, pre_s7});
	assign m_axis_tuser = sat_s7;

endmodule

### hw/rtl/sdcm_twiddle_rom.sv
// sdcm_twiddle_rom: constant cos/sin table of 2*pi*p/BINS in Q1.17, built at
// elaboration from a truncating Q30 series, with a registered read; uses sdcm_pkg.
module sdcm_twiddle_rom
	import sdcm_pkg::*;
#(
	parameter int BINS     = BINS_DEF,
	parameter int BIN_BITS = $clog2(BINS)
) (
	input  logic                clk,
	input  logic                en,
	input  logic [BIN_BITS-1:0] p,
	output twiddle_t            tw
);

	// clamp a Q30 value to 0..1 and round it to Q1.17
	function automatic longint to_q17(input longint acc);
		longint v;
		v = acc;
		if (v < 0)
			v = 0;
		if (v > longint'(ONE_Q30))
			v = longint'(ONE_Q30);
		return (v + 4096) >>> 13;
	endfunction

	// one table entry: fold to the first octant, series, unfold
	// BINS must be a power of two, unchecked, so the octant split is a shift and a mask
	function automatic twiddle_t tw_entry(input int g);
		longint unsigned e, oct, rem, a, x, x2, term;
		longint sacc, cacc, s, c, cq, sq;
		twiddle_t r;
		e    = 64'(8 * g);
		oct  = e >> BIN_BITS;
		rem  = e & (64'(BINS) - 64'd1);
		a    = oct[0] ? (64'(BINS) - rem) : rem;
		x    = (a * PI_Q30) >> (BIN_BITS + 2);
		x2   = (x * x) >> 30;
		// sine to x^9
		term = x;
		sacc = longint'(x);
		term = ((term * x2) >> 30) / 6;
		sacc = sacc - longint'(term);
		term = ((term * x2) >> 30) / 20;
		sacc = sacc + longint'(term);
		term = ((term * x2) >> 30) / 42;
		sacc = sacc - longint'(term);
		term = ((term * x2) >> 30) / 72;
		sacc = sacc + longint'(term);
		// cosine to x^10
		term = ONE_Q30;
		cacc = longint'(ONE_Q30);
		term = ((term * x2) >> 30) / 2;
		cacc = cacc - longint'(term);
		term = ((term * x2) >> 30) / 12;
		cacc = cacc + longint'(term);
		term = ((term * x2) >> 30) / 30;
		cacc = cacc - longint'(term);
		term = ((term * x2) >> 30) / 56;
		cacc = cacc + longint'(term);
		term = ((term * x2) >> 30) / 90;
		cacc = cacc - longint'(term);
		s = to_q17(sacc);
		c = to_q17(cacc);
		case (oct[2:0])
			3'd0: begin cq = c;  sq = s;  end
			3'd1: begin cq = s;  sq = c;  end
			3'd2: begin cq = -s; sq = c;  end
			3'd3: begin cq = -c; sq = s;  end
			3'd4: begin cq = -c; sq = -s; end
			3'd5: begin cq = -s; sq = -c; end
			3'd6: begin cq = s;  sq = -c; end
			default: begin cq = c; sq = -s; end
		endcase
		r.cos_v = TW_BITS'(cq);
		r.sin_v = TW_BITS'(sq);
		return r;
	endfunction

	twiddle_t rom_tab [BINS];

	// table contents, one constant per entry
	for (genvar g = 0; g < BINS; g++) begin : g_rom
		localparam twiddle_t ENTRY = tw_entry(g);
		assign rom_tab[g] = ENTRY;
	end

	// registered read
	always_ff @(posedge clk) begin
		if (en)
			tw <= rom_tab[p];
	end

endmodule

### hw/rtl/sdcm_checker.sv
// sdcm_checker: port-level assertions for ssca_downconvert_conj_multiply,
// bound to the top level below; uses sdcm_pkg.
module sdcm_checker
	import sdcm_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_axis_tvalid,
	input logic                                 s_axis_tready,
	input logic                                 m_axis_tvalid,
	input logic                                 m_axis_tready,
	input logic [((2*VALUE_BITS+7)/8)*8-1:0]    m_axis_tdata,
	input logic                                 m_axis_tuser
);

	localparam int V = VALUE_BITS;
	localparam logic [V-1:0] MAXV = {1'b0, {(V-1){1'b1}}};
	localparam logic [V-1:0] MINV = {1'b1, {(V-1){1'b0}}};

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// input back-pressure only when a result is waiting and stalled
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled with output free");

	// saturation flag only with a part at a range end
	a_sat_clip: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			m_axis_tdata[V-1:0] == MAXV || m_axis_tdata[V-1:0] == MINV ||
			m_axis_tdata[2*V-1:V] == MAXV || m_axis_tdata[2*V-1:V] == MINV)
		else $error("saturation flag without clipped part");

	// no result without an item ever accepted since reset
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 7) ||
			$past(m_axis_tvalid, 1))
		else $error("result appeared without an item");

endmodule

bind ssca_downconvert_conj_multiply sdcm_checker #(
	.VALUE_BITS (VALUE_BITS)
) u_sdcm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
